// ===== rtl/pdu_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
// Used by pdu_slot_ram and periodic_task_dispatcher_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pdu_pkg;

  // Table size and the usable capacity (task ids are three bits wide)
  localparam int TASK_SLOTS = 8;
  localparam int SLOT_CAP   = (TASK_SLOTS < 8) ? TASK_SLOTS : 8;
  localparam int IDX_W      = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0]       cnt_t;
  typedef logic [2:0]       task_id_t;
  typedef logic [15:0]      tick_t;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_SCAN   = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    RESP_CLEARED = 3'd0,
    RESP_CREATED = 3'd1,
    RESP_REFUSED = 3'd2,
    RESP_DUE     = 3'd3,
    RESP_IDLE    = 3'd4
  } resp_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_END
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    tick_t      period;
    tick_t      tick_now;
  } req_t;

  typedef struct packed {
    logic [2:0] resp_kind;
    task_id_t   task_id;
    logic       last_of_run;
  } resp_t;

  // One table entry
  typedef struct packed {
    tick_t period;
    tick_t ref_time;
  } slot_t;

  // Write port bundle of the slot memory
  typedef struct packed {
    logic  en;
    idx_t  addr;
    slot_t data;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pdu_slot_ram.sv =====
// Slot table memory: one write port, one read port, registered read data.
// Depends on pdu_pkg for the entry and write-port types.
`timescale 1ns / 1ps
`default_nettype none

module pdu_slot_ram (
  input  wire logic             clk_i,
  input  wire pdu_pkg::slot_wr_t wr_i,
  input  wire logic             rd_en_i,
  input  wire pdu_pkg::idx_t    rd_addr_i,
  output pdu_pkg::slot_t        rd_data_o
);

  pdu_pkg::slot_t mem_q [pdu_pkg::SLOT_CAP];
  pdu_pkg::slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Hold the read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/periodic_task_dispatcher_unit.sv =====
// Top level of the periodic task dispatcher: request decode, scan sequencer, output register.
// Depends on pdu_pkg and pdu_slot_ram.
`timescale 1ns / 1ps
`default_nettype none

// Periodic task dispatcher. Keeps up to eight task slots (period and reference tick) in a
// single-port-read, single-port-write slot memory. A clear or create transaction gives one
// result in the output register. A scan walks the used slots one per cycle through the
// memory read port while no due slot waits for room in the output register: it accepts
// the request and reads the first used slot, evaluates each used slot in turn, then closes
// with a final result. Due results are held back by one slot so that the last one
// can carry last_of_run; a scan with nothing due gives a single idle result. Clearing only
// resets the fill count: slots beyond the count are never read before they are rewritten.
// Input transactions are taken only while the sequencer is idle and the output register can
// take a result; request code 3 is taken and dropped without a result.
module periodic_task_dispatcher_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire pdu_pkg::req_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output pdu_pkg::resp_t      out_resp_o
);

  pdu_pkg::state_e   state_q, state_d;
  pdu_pkg::idx_t     idx_q, idx_d;
  pdu_pkg::cnt_t     used_q, used_d;
  pdu_pkg::tick_t    tick_q, tick_d;
  logic              pend_valid_q, pend_valid_d;
  pdu_pkg::idx_t     pend_id_q, pend_id_d;
  logic              out_valid_q, out_valid_d;
  pdu_pkg::resp_t    out_q, out_d;

  pdu_pkg::slot_wr_t slot_wr;
  logic              rd_en;
  pdu_pkg::idx_t     rd_addr;
  pdu_pkg::slot_t    rd_data;

  logic              out_free;
  logic              in_acc;
  logic              emit;
  pdu_pkg::tick_t    elapsed;
  logic              due;
  logic              last_slot;

  pdu_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .wr_i      (slot_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The output register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != pdu_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Wrap-safe elapsed time of the slot under evaluation
  assign elapsed   = tick_q - rd_data.ref_time;
  assign due       = (elapsed >= rd_data.period);
  assign last_slot = (pdu_pkg::cnt_t'(idx_q) + pdu_pkg::cnt_t'(1)) == used_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    used_d       = used_q;
    tick_d       = tick_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_d        = out_q;
    emit         = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    slot_wr      = '0;

    case (state_q)
      pdu_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_req_i.req_type)
            pdu_pkg::REQ_CLEAR: begin
              used_d = '0;
              emit   = 1'b1;
              out_d  = '{resp_kind: pdu_pkg::RESP_CLEARED, task_id: '0, last_of_run: 1'b1};
            end
            pdu_pkg::REQ_CREATE: begin
              emit = 1'b1;
              if ((in_req_i.period == '0) ||
                  (used_q >= pdu_pkg::cnt_t'(pdu_pkg::SLOT_CAP))) begin
                out_d = '{resp_kind: pdu_pkg::RESP_REFUSED, task_id: '0, last_of_run: 1'b1};
              end else begin
                // Reference one period back so the task is due on the first scan
                slot_wr.en            = 1'b1;
                slot_wr.addr          = used_q[pdu_pkg::IDX_W-1:0];
                slot_wr.data.period   = in_req_i.period;
                slot_wr.data.ref_time = in_req_i.tick_now - in_req_i.period;
                used_d                = used_q + pdu_pkg::cnt_t'(1);
                out_d = '{resp_kind:   pdu_pkg::RESP_CREATED,
                          task_id:     pdu_pkg::task_id_t'(used_q[pdu_pkg::IDX_W-1:0]),
                          last_of_run: 1'b1};
              end
            end
            pdu_pkg::REQ_SCAN: begin
              tick_d       = in_req_i.tick_now;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              if (used_q == '0) begin
                state_d = pdu_pkg::ST_END;
              end else begin
                // Fetch slot zero now, evaluate it next cycle
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = pdu_pkg::ST_EVAL;
              end
            end
            default: begin
              // Undefined request: drop it
            end
          endcase
        end
      end

      pdu_pkg::ST_EVAL: begin
        // A due slot with a result already pending needs room in the output register
        if (!due || !pend_valid_q || out_free) begin
          if (due) begin
            slot_wr.en            = 1'b1;
            slot_wr.addr          = idx_q;
            slot_wr.data.period   = rd_data.period;
            slot_wr.data.ref_time = rd_data.ref_time + rd_data.period;
            if (pend_valid_q) begin
              emit  = 1'b1;
              out_d = '{resp_kind:   pdu_pkg::RESP_DUE,
                        task_id:     pdu_pkg::task_id_t'(pend_id_q),
                        last_of_run: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_id_d    = idx_q;
          end
          if (last_slot) begin
            state_d = pdu_pkg::ST_END;
          end else begin
            // Advance to the next slot; the read data holds otherwise
            rd_en   = 1'b1;
            rd_addr = idx_q + pdu_pkg::idx_t'(1);
            idx_d   = idx_q + pdu_pkg::idx_t'(1);
          end
        end
      end

      pdu_pkg::ST_END: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_valid_q) begin
            out_d = '{resp_kind:   pdu_pkg::RESP_DUE,
                      task_id:     pdu_pkg::task_id_t'(pend_id_q),
                      last_of_run: 1'b1};
          end else begin
            out_d = '{resp_kind: pdu_pkg::RESP_IDLE, task_id: '0, last_of_run: 1'b1};
          end
          pend_valid_d = 1'b0;
          state_d      = pdu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pdu_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pdu_pkg::ST_IDLE;
      used_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tick_q    <= tick_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_q;

endmodule

`default_nettype wire
